### src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and codes of the button press classifier
// Holds mode codes, event codes, register indexes, item kinds and the
// threshold bundle that goes from the top level to every button unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // field widths
    localparam int PIN_W   = 4;
    localparam int IDX_W   = 2;
    localparam int EVENT_W = 2;
    localparam int COUNT_W = 8;
    localparam int MODE_W  = 3;
    localparam int THR_W   = 8;
    localparam int CFG_IDX_W = 2;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // item kinds carried in s_tuser
    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // per-button mode codes
    localparam logic [MODE_W-1:0] MODE_OFF          = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON           = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSHING      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PUSHED       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LONG_PUSH    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LONG_PUSHING = 3'd5;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_REPEAT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PUSH_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_THR = 2'd2;

    // configuration reset values
    localparam logic [THR_W-1:0] PUSH_THR_RST   = 8'd3;
    localparam logic [THR_W-1:0] LONG_THR_RST   = 8'd100;
    localparam logic [THR_W-1:0] REPEAT_THR_RST = 8'd20;

    // threshold bundle
    typedef struct packed {
        logic [THR_W-1:0] push_thr;
        logic [THR_W-1:0] long_thr;
        logic [THR_W-1:0] repeat_thr;
    } thresh_t;

endpackage

### src/bpc_button.sv
// ----------------------------------------------------------------------------
// bpc_button: state and press counter of one button
// Updates mode and count on a scan tick, and consumes the pending event on
// a read of this button, answering the event code in the same cycle.
// ----------------------------------------------------------------------------
module bpc_button (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          scan_en,
    input  logic                          read_en,
    input  logic                          pressed,
    input  bpc_pkg::thresh_t              thr,
    output logic [bpc_pkg::EVENT_W-1:0]   event_code
);
    import bpc_pkg::*;

    logic [MODE_W-1:0]  mode_reg,  mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] count_inc;

    // held ticks advance before the mode is examined
    assign count_inc = pressed ? COUNT_W'(count_reg + 1'b1) : count_reg;

    // next mode, count and event
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        event_code = EV_NONE;
        if (scan_en) begin
            count_next = count_inc;
            case (mode_reg)
                MODE_OFF: begin
                    if (pressed) mode_next = MODE_ON;
                    count_next = '0;
                end
                MODE_ON: begin
                    if (!pressed) mode_next = MODE_OFF;
                    else if (count_inc > thr.push_thr) mode_next = MODE_PUSHING;
                end
                MODE_PUSHING: begin
                    if (!pressed) mode_next = MODE_PUSHED;
                    else if (count_inc > thr.long_thr) mode_next = MODE_LONG_PUSH;
                end
                MODE_PUSHED: begin
                    if (pressed) mode_next = MODE_PUSHING;
                end
                MODE_LONG_PUSH, MODE_LONG_PUSHING: begin
                    if (!pressed) mode_next = MODE_OFF;
                end
                default: begin
                    mode_next = MODE_OFF;
                end
            endcase
        end else if (read_en) begin
            case (mode_reg)
                MODE_PUSHED: begin
                    mode_next  = MODE_OFF;
                    event_code = EV_SHORT;
                end
                MODE_LONG_PUSH: begin
                    mode_next  = MODE_LONG_PUSHING;
                    count_next = count_reg - thr.long_thr;
                    event_code = EV_LONG;
                end
                MODE_LONG_PUSHING: begin
                    if (count_reg > thr.repeat_thr) begin
                        count_next = count_reg - thr.repeat_thr;
                        event_code = EV_REPEAT;
                    end
                end
                default: begin
                    event_code = EV_NONE;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OFF;
            count_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

### src/button_press_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_classifier_core: short, long and auto-repeat press classifier
// Per-button debounce state machines fed by scan ticks, queried by reads.
// ----------------------------------------------------------------------------
// One request is accepted per clock cycle while s_tready is high. A
// request sits in the input register while every button unit works on it,
// and its result is then captured in the result register, which drives
// the m_ side. The result register decouples the sides. While a result
// waits on m_tready, s_tready stays high only as long as the input register
// is empty, so one more request can be taken before the input stalls. A
// scan tick (s_tuser low) updates all buttons and answers event 0. A read
// (s_tuser high) consumes the named button's event.
// Configuration writes are taken at any time and must only be issued while
// no request is in flight.
module button_press_classifier_core #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpc_pkg::S_TDATA_W-1:0]   s_tdata,   // pin_levels[3:0], button_index[5:4]
    input  logic                            s_tuser,   // kind
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpc_pkg::M_TDATA_W-1:0]   m_tdata,   // event_code[1:0]
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::THR_W-1:0]       cfg_data
);
    import bpc_pkg::*;

    thresh_t            thr_reg;
    logic               in_valid_reg;
    logic               in_kind_reg;
    logic [PIN_W-1:0]   in_pins_reg;
    logic [IDX_W-1:0]   in_idx_reg;
    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [EVENT_W-1:0] event_next;
    logic               advance;
    logic               fire;
    logic [EVENT_W-1:0] btn_event [NUM_BUTTONS];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.push_thr   <= PUSH_THR_RST;
            thr_reg.long_thr   <= LONG_THR_RST;
            thr_reg.repeat_thr <= REPEAT_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PUSH_THR:   thr_reg.push_thr   <= cfg_data;
                REG_LONG_THR:   thr_reg.long_thr   <= cfg_data;
                REG_REPEAT_THR: thr_reg.repeat_thr <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake between input and result registers
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_pins_reg <= s_tdata[PIN_W-1:0];
            in_idx_reg  <= s_tdata[PIN_W+IDX_W-1:PIN_W];
        end
    end

    // button units
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        logic pressed;
        logic read_sel;

        if (b < PIN_W) begin : g_pin
            assign pressed = !in_pins_reg[b];
        end else begin : g_nopin
            assign pressed = 1'b0;
        end

        assign read_sel = (int'(in_idx_reg) == b);

        bpc_button u_button (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .scan_en    (fire && (in_kind_reg == KIND_SCAN)),
            .read_en    (fire && (in_kind_reg == KIND_READ) && read_sel),
            .pressed    (pressed),
            .thr        (thr_reg),
            .event_code (btn_event[b])
        );
    end

    // only the read button can answer nonzero
    always_comb begin
        event_next = EV_NONE;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            event_next = event_next | btn_event[i];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_event_reg <= event_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-EVENT_W){1'b0}}, out_event_reg};

    // a held request is never dropped while the result side stalls
    a_hold_in : assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("request lost from input register");

    // a processed request always shows up as a result
    a_fire_out : assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("processed request produced no result");

    // scan ticks never report an event
    a_scan_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (in_kind_reg == KIND_SCAN) |=> m_tdata[EVENT_W-1:0] == EV_NONE)
        else $error("scan tick reported an event");

endmodule

### tb/button_press_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// button_press_classifier_core_tb: self-checking bench for the press classifier
// Drives scan and read requests through the s_ stream, predicts every event
// code with a cycle-free model of the per-button state machines and compares
// it with the m_ stream. Threshold sets change between phases while idle.
// ----------------------------------------------------------------------------
module button_press_classifier_core_tb;
    import bpc_pkg::*;

    localparam int NUM_BUTTONS = 4;

    typedef struct {
        logic               kind;
        logic [PIN_W-1:0]   pins;
        logic [IDX_W-1:0]   idx;
    } press_req_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [THR_W-1:0]     val;
    } thr_write_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // pin_levels[3:0], button_index[5:4]
    logic                   s_tuser = 1'b0; // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // event_code[1:0]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [THR_W-1:0]       cfg_data = '0;

    // predicted block state
    logic [THR_W-1:0]   thr_push = PUSH_THR_RST;
    logic [THR_W-1:0]   thr_long = LONG_THR_RST;
    logic [THR_W-1:0]   thr_repeat = REPEAT_THR_RST;
    logic [MODE_W-1:0]  btn_mode [NUM_BUTTONS];
    logic [COUNT_W-1:0] btn_count [NUM_BUTTONS];

    press_req_t         pending_requests [$];
    thr_write_t         pending_writes [$];
    logic [EVENT_W-1:0] expected_events [$];
    press_req_t         cur_req;
    thr_write_t         cur_write;
    logic [EVENT_W-1:0] want_event;

    int   fail_count = 0;
    int   src_gap = 0;
    int   sink_stall = 0;
    bit   idle_on = 1'b1;
    bit   quiet = 1'b0;

    // hold plan per button for well-formed press sequences
    bit   plan_held [NUM_BUTTONS];
    int   plan_left [NUM_BUTTONS];

    button_press_classifier_core #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // event a request produces, updating the predicted state
    function automatic logic [EVENT_W-1:0] classify_request(input press_req_t req);
        logic               pressed;
        logic [COUNT_W-1:0] cnt;
        logic [MODE_W-1:0]  md;
        logic [EVENT_W-1:0] ev;
        ev = EV_NONE;
        if (req.kind == KIND_SCAN) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                pressed = (b < PIN_W) ? !req.pins[b] : 1'b0;
                cnt = btn_count[b];
                md = btn_mode[b];
                // count first, then look at the mode
                if (pressed)
                    cnt = cnt + 1'b1;
                case (md)
                    MODE_OFF: begin
                        if (pressed)
                            md = MODE_ON;
                        cnt = '0;
                    end
                    MODE_ON: begin
                        if (!pressed)
                            md = MODE_OFF;
                        else if (cnt > thr_push)
                            md = MODE_PUSHING;
                    end
                    MODE_PUSHING: begin
                        if (!pressed)
                            md = MODE_PUSHED;
                        else if (cnt > thr_long)
                            md = MODE_LONG_PUSH;
                    end
                    MODE_PUSHED: begin
                        if (pressed)
                            md = MODE_PUSHING;
                    end
                    MODE_LONG_PUSH, MODE_LONG_PUSHING: begin
                        if (!pressed)
                            md = MODE_OFF;
                    end
                    default: md = MODE_OFF;
                endcase
                btn_count[b] = cnt;
                btn_mode[b] = md;
            end
        end else if (int'(req.idx) < NUM_BUTTONS) begin
            // a read consumes the pending event
            case (btn_mode[req.idx])
                MODE_PUSHED: begin
                    btn_mode[req.idx] = MODE_OFF;
                    ev = EV_SHORT;
                end
                MODE_LONG_PUSH: begin
                    btn_mode[req.idx] = MODE_LONG_PUSHING;
                    btn_count[req.idx] = btn_count[req.idx] - thr_long;
                    ev = EV_LONG;
                end
                MODE_LONG_PUSHING: begin
                    if (btn_count[req.idx] > thr_repeat) begin
                        btn_count[req.idx] = btn_count[req.idx] - thr_repeat;
                        ev = EV_REPEAT;
                    end
                end
                default: ev = EV_NONE;
            endcase
        end
        return ev;
    endfunction

    // driver: requests, threshold writes and result back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
            m_tready <= 1'b0;
            thr_push = PUSH_THR_RST;
            thr_long = LONG_THR_RST;
            thr_repeat = REPEAT_THR_RST;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                btn_mode[b] = MODE_OFF;
                btn_count[b] = '0;
            end
        end else begin
            if ($urandom_range(0, 149) == 0)
                idle_on = !idle_on;

            // request side
            if (s_tvalid && s_tready)
                expected_events.push_back(classify_request(cur_req));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, cur_req.idx, cur_req.pins};
                    s_tuser <= cur_req.kind;
                    if (!quiet && idle_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end

            // threshold writes
            if (cfg_valid && cfg_ready) begin
                case (cur_write.idx)
                    REG_PUSH_THR:   thr_push = cur_write.val;
                    REG_LONG_THR:   thr_long = cur_write.val;
                    REG_REPEAT_THR: thr_repeat = cur_write.val;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (pending_writes.size() != 0) begin
                    cur_write = pending_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= cur_write.idx;
                    cfg_data <= cur_write.val;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end

            // result back-pressure
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && idle_on && $urandom_range(0, 5) == 0)
                    sink_stall = $urandom_range(1, 17);
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $error("event_code: no result expected, actual %0d", m_tdata[EVENT_W-1:0]);
                fail_count++;
            end else begin
                want_event = expected_events.pop_front();
                if (m_tdata[EVENT_W-1:0] !== want_event) begin
                    $error("event_code mismatch: expected %0d, actual %0d",
                           want_event, m_tdata[EVENT_W-1:0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_request(input logic kind, input logic [PIN_W-1:0] pins,
                                 input logic [IDX_W-1:0] idx);
        press_req_t req;
        req.kind = kind;
        req.pins = pins;
        req.idx = idx;
        pending_requests.push_back(req);
    endtask

    // wait until every request is accepted and answered
    task automatic wait_for_drain();
        do
            @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_events.size() != 0);
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] push_v,
                                  input logic [THR_W-1:0] long_v,
                                  input logic [THR_W-1:0] repeat_v);
        thr_write_t wr;
        wait_for_drain();
        wr.idx = REG_PUSH_THR;
        wr.val = push_v;
        pending_writes.push_back(wr);
        wr.idx = REG_LONG_THR;
        wr.val = long_v;
        pending_writes.push_back(wr);
        wr.idx = REG_REPEAT_THR;
        wr.val = repeat_v;
        pending_writes.push_back(wr);
        do
            @(negedge aclk);
        while (pending_writes.size() != 0 || cfg_valid);
    endtask

    // mostly press/release sequences per button, with reads and noise
    task automatic random_phase(input int count);
        logic [PIN_W-1:0] pins;
        int               r;
        int               lim;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                queue_request(KIND_READ, PIN_W'($urandom), IDX_W'($urandom));
            end else if (r < 36) begin
                queue_request(KIND_SCAN, PIN_W'($urandom), IDX_W'($urandom));
            end else begin
                lim = int'(thr_long) + 3 * int'(thr_repeat) + 4;
                if (lim > 300)
                    lim = 300;
                for (int b = 0; b < PIN_W; b++) begin
                    if (plan_left[b] == 0) begin
                        plan_held[b] = !plan_held[b];
                        if (!plan_held[b])
                            plan_left[b] = $urandom_range(1, 6);
                        else if ($urandom_range(0, 2) == 0)
                            plan_left[b] = $urandom_range(1, int'(thr_push) + 3);
                        else
                            plan_left[b] = $urandom_range(1, lim);
                    end
                    plan_left[b]--;
                    pins[b] = !plan_held[b];
                end
                queue_request(KIND_SCAN, pins, IDX_W'($urandom));
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            plan_held[b] = 1'b0;
            plan_left[b] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset thresholds: idle reads, then a short press on every button
        for (int i = 0; i < NUM_BUTTONS; i++)
            queue_request(KIND_READ, 4'hF, IDX_W'(i));
        repeat (5) queue_request(KIND_SCAN, 4'h0, 2'd3);
        queue_request(KIND_SCAN, 4'hF, 2'd0);
        for (int i = 0; i < NUM_BUTTONS; i++)
            queue_request(KIND_READ, 4'h0, IDX_W'(i));

        // low thresholds: long press, repeat not yet due, then a repeat
        set_thresholds(8'd0, 8'd2, 8'd1);
        repeat (4) queue_request(KIND_SCAN, 4'h0, 2'd1);
        queue_request(KIND_READ, 4'h5, 2'd0);
        queue_request(KIND_READ, 4'hA, 2'd0);
        queue_request(KIND_SCAN, 4'h0, 2'd2);
        queue_request(KIND_READ, 4'h0, 2'd0);
        queue_request(KIND_READ, 4'hF, 2'd1);
        queue_request(KIND_SCAN, 4'hF, 2'd3);
        random_phase(150);

        set_thresholds(PUSH_THR_RST, LONG_THR_RST, REPEAT_THR_RST);
        random_phase(300);
        set_thresholds(8'd0, 8'd0, 8'd0);
        random_phase(150);
        set_thresholds(8'd255, 8'd255, 8'd255);
        random_phase(300);
        repeat (3) begin
            set_thresholds(THR_W'($urandom_range(0, 6)), THR_W'($urandom_range(0, 40)),
                           THR_W'($urandom_range(0, 12)));
            random_phase(150);
        end

        // closing phase runs at full rate
        set_thresholds(8'd1, 8'd8, 8'd3);
        quiet = 1'b1;
        random_phase(200);

        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### button_press_classifier_core.f
src/bpc_pkg.sv
src/bpc_button.sv
src/button_press_classifier_core.sv
tb/button_press_classifier_core_tb.sv
